FILE: hw/rtl/bucket_grid_object_store_macros.svh
// assertion macros for the bucket grid store checker
`ifndef BUCKET_GRID_OBJECT_STORE_MACROS_SVH
`define BUCKET_GRID_OBJECT_STORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define BGS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgs check failed");
// next-cycle implication checked outside reset
`define BGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgs check failed");
`endif

FILE: hw/rtl/bgs_pkg.sv
// shared types and codes for the bucket grid object store
package bgs_pkg;
   localparam int OP_BITS  = 3;
   localparam int CNT_BITS = 7;
   localparam int PK_BITS  = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD    = 3'd0,
      OP_SELECT = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_DISCARD = 3'd3,
      OP_PEAK   = 3'd4,
      OP_WINDOW = 3'd5,
      OP_RSVD6  = 3'd6,
      OP_RSVD7  = 3'd7
   } opcode_type;

   localparam logic CSR_CELL_LIMIT   = 1'b0;
   localparam logic CSR_CELLS_IN_USE = 1'b1;

   // one decoded command between front and back
   typedef struct packed {
      opcode_type  op;
      logic [15:0] cell_index;
      logic [63:0] handle;
      logic [15:0] range_low;
      logic [15:0] range_high;
      logic [2:0]  threshold;
      logic [3:0]  radius;
   } cmd_type;
endpackage

FILE: hw/rtl/bgs_front.sv
// front end: takes request items and queues them as commands
module bgs_front #(
   parameter int DEPTH = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  bgs_pkg::cmd_type in_cmd,
   output logic            out_valid,
   input  logic            out_ready,
   output bgs_pkg::cmd_type out_cmd
);
   import bgs_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type queue_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] fill_ff, fill_in;
   logic push, pop;

   assign in_ready  = (fill_ff != (AW+1)'(DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_cmd   = queue_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         queue_ff[wr_ff] <= in_cmd;
      end
   end
endmodule

FILE: hw/rtl/bgs_back.sv
// back end: walks the cells for each command and emits result items
module bgs_back #(
   parameter int NUM_CELLS     = 16,
   parameter int CELL_CAPACITY = 4,
   parameter int HANDLE_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  bgs_pkg::cmd_type cmd,
   input  logic [2:0]       cell_limit,
   input  logic [4:0]       cells_in_use,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_handle,
   output logic [6:0]       rsp_count,
   output logic [2:0]       rsp_peak,
   output logic             rsp_last
);
   import bgs_pkg::*;
   localparam int CB = $clog2(NUM_CELLS + 1);       // cell counter, holds NUM_CELLS
   localparam int IB = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int KB = $clog2(CELL_CAPACITY + 1);   // slot count
   localparam int SB = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
   localparam int DEPTH = NUM_CELLS * CELL_CAPACITY;
   localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TB = 14;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_EMIT = 6'b000100,
      ST_RD   = 6'b001000,
      ST_OUT  = 6'b010000,
      ST_WAIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [KB-1:0] counts_ff [NUM_CELLS];
   logic [HANDLE_BITS-1:0] store_mem [DEPTH];
   logic [HANDLE_BITS-1:0] rd_data_ff;

   cmd_type cmd_ff;
   logic [CB-1:0] cell_ff, cell_in, hi_ff;
   logic [KB-1:0] slot_ff, slot_in;
   logic [TB-1:0] total_ff, total_in;
   logic [KB-1:0] peak_ff, peak_in;
   logic [6:0] emitted_ff, emitted_in;
   logic scan_more;

   logic out_v_ff, out_st_ff, out_last_ff;
   logic [HANDLE_BITS-1:0] out_h_ff;
   logic [6:0] out_cnt_ff;
   logic [2:0] out_pk_ff;

   // effective configuration
   logic [CB-1:0] n_eff;
   logic [KB-1:0] lim_eff;
   assign n_eff = (32'(cells_in_use) > NUM_CELLS) ? CB'(NUM_CELLS) : CB'(cells_in_use);
   assign lim_eff = (32'(cell_limit) > CELL_CAPACITY) ? KB'(CELL_CAPACITY) : KB'(cell_limit);

   // decode of the incoming command
   logic signed [17:0] c_idx, c_lo, c_hi, w_lo, w_hi, lo_cl, hi_cl, n_m1;
   logic [CB-1:0] lo_start, hi_end;
   logic range_empty;
   logic [HANDLE_BITS-1:0] h_in;
   logic [IB-1:0] add_cell;
   logic add_ok;

   always_comb begin
      c_idx = 18'(signed'(cmd.cell_index));
      n_m1 = 18'(signed'({1'b0, n_eff})) - 18'sd1;
      if (cmd.op == OP_WINDOW) begin
         c_lo = c_idx - 18'(cmd.radius);
         c_hi = c_idx + 18'(cmd.radius);
      end else if (cmd.op == OP_SELECT) begin
         c_lo = 18'(signed'(cmd.range_low));
         c_hi = 18'(signed'(cmd.range_high));
      end else begin
         c_lo = '0;
         c_hi = n_m1;
      end
      w_lo = c_lo;
      w_hi = c_hi;
      lo_cl = (w_lo < 0) ? 18'sd0 : w_lo;
      hi_cl = (w_hi > n_m1) ? n_m1 : w_hi;
      range_empty = (lo_cl > hi_cl);
      lo_start = CB'(lo_cl);
      hi_end = CB'(hi_cl);
      h_in = HANDLE_BITS'(cmd.handle);
      add_cell = IB'(cmd.cell_index);
      add_ok = (c_idx >= 0) && (c_idx < 18'(signed'({1'b0, n_eff}))) && (h_in != '0)
               && (counts_ff[add_cell] < lim_eff);
   end

   assign cmd_ready = (state_ff == ST_IDLE) && !out_v_ff;

   logic start;
   assign start = cmd_valid && cmd_ready;
   logic out_free;
   assign out_free = !out_v_ff || rsp_ready;

   logic [IB-1:0] cur;
   assign cur = IB'(cell_ff);
   assign scan_more = (cell_ff <= hi_ff) && (cell_ff < CB'(NUM_CELLS));

   // emit-side helpers
   logic [AB-1:0] rd_addr;
   assign rd_addr = AB'(32'(cur) * CELL_CAPACITY + 32'(slot_ff));
   logic [6:0] tot_sat;
   assign tot_sat = (total_ff > TB'(127)) ? 7'd127 : 7'(total_ff);

   // next emit position after the current slot
   logic [CB-1:0] nx_cell;
   logic [KB-1:0] nx_slot;
   logic nx_done;
   always_comb begin
      nx_cell = cell_ff;
      nx_slot = slot_ff + 1'b1;
      if (nx_slot >= counts_ff[cur]) begin
         nx_cell = cell_ff + 1'b1;
         nx_slot = '0;
      end
      // done at the result cap or once every handle of the range has gone out
      nx_done = (emitted_ff + 7'd1 >= 7'd64) || (nx_cell > hi_ff)
                || (TB'(emitted_ff) + TB'(1) >= total_ff);
   end

   logic emit_now;
   logic [6:0] e_cnt;
   logic [2:0] e_pk;
   logic e_st, e_last;
   logic [HANDLE_BITS-1:0] e_h;

   always_comb begin
      state_in = state_ff;
      cell_in = cell_ff;
      slot_in = slot_ff;
      total_in = total_ff;
      peak_in = peak_ff;
      emitted_in = emitted_ff;
      emit_now = 1'b0;
      e_st = 1'b0; e_h = '0; e_cnt = '0; e_pk = '0; e_last = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cell_in = range_empty ? CB'(NUM_CELLS) : lo_start;
               total_in = '0;
               peak_in = '0;
               slot_in = '0;
               emitted_in = '0;
               unique case (cmd.op)
                  OP_ADD: begin
                     emit_now = 1'b1;
                     e_st = !add_ok;
                  end
                  OP_CLEAR, OP_RSVD6, OP_RSVD7: emit_now = 1'b1;
                  default: state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_more) begin
               if (cmd_ff.op == OP_DISCARD) begin
                  if (counts_ff[cur] > KB'(cmd_ff.threshold)) begin
                     total_in = total_ff + 1'b1;
                  end
               end else begin
                  total_in = total_ff + TB'(counts_ff[cur]);
                  if (counts_ff[cur] > peak_ff) peak_in = counts_ff[cur];
               end
               cell_in = cell_ff + 1'b1;
            end else if (cmd_ff.op == OP_SELECT && total_ff != '0) begin
               state_in = ST_EMIT;
               cell_in = CB'(cmd_ff.range_low[15] ? '0 : cmd_ff.range_low);
               slot_in = '0;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_EMIT: begin
            // skip empty cells, then read a slot
            if (counts_ff[cur] == '0) begin
               cell_in = cell_ff + 1'b1;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               emit_now = 1'b1;
               e_h = rd_data_ff;
               e_cnt = tot_sat;
               e_last = nx_done;
               emitted_in = emitted_ff + 1'b1;
               cell_in = nx_cell;
               slot_in = nx_slot;
               state_in = nx_done ? ST_IDLE : ST_EMIT;
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               emit_now = 1'b1;
               e_cnt = tot_sat;
               if (cmd_ff.op == OP_PEAK) begin
                  e_pk = 3'(peak_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command latch with clamped range end, store read and write, and result registers
   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff <= cmd;
         hi_ff <= range_empty ? '0 : hi_end;
      end
      if (state_ff == ST_RD) begin
         rd_data_ff <= store_mem[rd_addr];
      end
      if (start && cmd.op == OP_ADD && add_ok) begin
         store_mem[AB'(32'(add_cell) * CELL_CAPACITY + 32'(counts_ff[add_cell]))] <= h_in;
      end
      if (emit_now) begin
         out_st_ff <= e_st;
         out_h_ff <= e_h;
         out_cnt_ff <= e_cnt;
         out_pk_ff <= e_pk;
         out_last_ff <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         cell_ff <= '0;
         slot_ff <= '0;
         total_ff <= '0;
         peak_ff <= '0;
         emitted_ff <= '0;
         for (int i = 0; i < NUM_CELLS; i++) counts_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         cell_ff <= cell_in;
         slot_ff <= slot_in;
         total_ff <= total_in;
         peak_ff <= peak_in;
         emitted_ff <= emitted_in;
         if (emit_now) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
         if (start && cmd.op == OP_ADD && add_ok) begin
            counts_ff[add_cell] <= counts_ff[add_cell] + 1'b1;
         end
         if (start && cmd.op == OP_CLEAR) begin
            for (int i = 0; i < NUM_CELLS; i++) counts_ff[i] <= '0;
         end
         if (state_ff == ST_SCAN && scan_more && cmd_ff.op == OP_DISCARD
             && counts_ff[cur] > KB'(cmd_ff.threshold)) begin
            counts_ff[cur] <= '0;
         end
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_status = out_st_ff;
   assign rsp_handle = out_h_ff;
   assign rsp_count  = out_cnt_ff;
   assign rsp_peak   = out_pk_ff;
   assign rsp_last   = out_last_ff;
endmodule

FILE: hw/rtl/bucket_grid_object_store.sv
// top level of the bucket grid object store
//  channel  dir  fields
//  req_     in   tdata: opcode, cell_index, object_handle, range_low, range_high,
//                threshold, radius
//  rsp_     out  tdata: status, handle_out, count, peak; tlast: last
//  csr_     in   index 0 cell_limit, 1 cells_in_use
// add, clear and unused opcodes answer without a scan; the others scan the cells of
// their range, all cells in use for discard and peak; select then emits each handle
// through the single store read port, stepping over each empty cell it crosses.
// reset is synchronous and clears counts and control registers; the handle store is
// not cleared. a two-entry command queue lets requests land while results stall.
module bucket_grid_object_store #(
   parameter int NUM_CELLS     = 16,
   parameter int CELL_CAPACITY = 4,
   parameter int HANDLE_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], cell_index[18:3], object_handle[34:19], range_low[50:35],
   // range_high[66:51], threshold[69:67], radius[73:70]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[0], handle_out[16:1], count[23:17], peak[26:24]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);
   import bgs_pkg::*;

   cmd_type in_cmd, q_cmd;
   logic q_valid, q_ready;
   logic [2:0] cell_limit_ff;
   logic [4:0] cells_in_use_ff;
   logic st;
   logic [HANDLE_BITS-1:0] h;
   logic [6:0] cnt;
   logic [2:0] pk;

   always_comb begin
      in_cmd.op         = opcode_type'(req_tdata[2:0]);
      in_cmd.cell_index = req_tdata[18:3];
      in_cmd.handle     = 64'(req_tdata[34:19]);
      in_cmd.range_low  = req_tdata[50:35];
      in_cmd.range_high = req_tdata[66:51];
      in_cmd.threshold  = req_tdata[69:67];
      in_cmd.radius     = req_tdata[73:70];
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_limit_ff <= 3'd4;
         cells_in_use_ff <= 5'd16;
      end else if (csr_valid) begin
         if (csr_index == CSR_CELL_LIMIT) cell_limit_ff <= csr_data[2:0];
         else cells_in_use_ff <= csr_data;
      end
   end

   bgs_front #(.DEPTH(2)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   bgs_back #(
      .NUM_CELLS(NUM_CELLS), .CELL_CAPACITY(CELL_CAPACITY), .HANDLE_BITS(HANDLE_BITS)
   ) u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .cell_limit(cell_limit_ff), .cells_in_use(cells_in_use_ff),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_status(st), .rsp_handle(h), .rsp_count(cnt), .rsp_peak(pk),
      .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, pk, cnt, 16'(h), st};
endmodule

FILE: hw/rtl/bgs_checker.sv
// port-level checker for the bucket grid object store, bound to the top level
`include "bucket_grid_object_store_macros.svh"
module bgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_ready
);
   `BGS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BGS_ASSERT_IMPL(a_status_single, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tlast && rsp_tdata[16:1] == 16'd0)
   `BGS_ASSERT_IMPL(a_handle_no_peak, clock, reset, rsp_tvalid && rsp_tdata[16:1] != 16'd0, rsp_tdata[26:24] == 3'd0)
   `BGS_ASSERT_IMPL(a_csr_ready, clock, reset, 1'b1, csr_ready)
endmodule

bind bucket_grid_object_store bgs_checker u_bgs_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .csr_ready(csr_ready)
);

FILE: tb/sv/bucket_grid_object_store_test.sv
// self-checking testbench for the bucket grid object store
`timescale 1ns / 1ps

module bucket_grid_object_store_test;
   import bgs_pkg::*;

   typedef struct {
      logic        status;
      logic [15:0] handle_out;
      logic [6:0]  count;
      logic [2:0]  peak;
      logic        last;
   } grid_result_type;

   // mirror of the grid and the results still owed by the block
   class grid_scoreboard;
      logic [2:0]   counts[16];
      logic [15:0]  handles[64];
      int           limit_reg;
      int           cells_reg;
      grid_result_type owed[$];
      int           mismatches;

      function void reset_grid();
         foreach (counts[j]) counts[j] = 0;
         limit_reg = 4;
         cells_reg = 16;
      endfunction

      function void write_reg(logic idx, logic [4:0] value);
         if (idx == CSR_CELL_LIMIT) limit_reg = value[2:0];
         else cells_reg = value;
      endfunction

      function void push(logic st, logic [15:0] h, int cnt, int pk, logic lst);
         grid_result_type r;
         r.status = st;
         r.handle_out = h;
         r.count = (cnt > 127) ? 7'd127 : cnt[6:0];
         r.peak = pk[2:0];
         r.last = lst;
         owed.push_back(r);
      endfunction

      function void note_item(logic [79:0] d);
         opcode_type op;
         int n, lim, j, lo, hi, total, pk, emitted, th;
         logic [15:0] h;
         op = opcode_type'(d[2:0]);
         n = (cells_reg > 16) ? 16 : cells_reg;
         lim = (limit_reg > 4) ? 4 : limit_reg;
         total = 0;
         pk = 0;
         emitted = 0;
         case (op)
            OP_ADD: begin
               j = $signed(d[18:3]);
               h = d[34:19];
               if (j >= 0 && j < n && h != 0 && counts[j] < lim) begin
                  handles[j * 4 + counts[j]] = h;
                  counts[j] = counts[j] + 1;
                  push(0, 0, 0, 0, 1);
               end else push(1, 0, 0, 0, 1);
            end
            OP_SELECT: begin
               lo = $signed(d[50:35]);
               hi = $signed(d[66:51]);
               if (lo < 0) lo = 0;
               if (hi > n - 1) hi = n - 1;
               for (j = lo; j <= hi; j++) total += counts[j];
               if (total == 0) push(0, 0, 0, 0, 1);
               else begin
                  for (j = lo; j <= hi; j++)
                     for (int k = 0; k < counts[j]; k++)
                        if (emitted < 64) begin
                           push(0, handles[j * 4 + k], total, 0, 0);
                           emitted++;
                        end
                  owed[$].last = 1;
               end
            end
            OP_CLEAR: begin
               foreach (counts[i]) counts[i] = 0;
               push(0, 0, 0, 0, 1);
            end
            OP_DISCARD: begin
               th = d[69:67];
               for (j = 0; j < n; j++)
                  if (counts[j] > th) begin
                     counts[j] = 0;
                     total++;
                  end
               push(0, 0, total, 0, 1);
            end
            OP_PEAK: begin
               for (j = 0; j < n; j++) begin
                  total += counts[j];
                  if (counts[j] > pk) pk = counts[j];
               end
               push(0, 0, total, pk, 1);
            end
            OP_WINDOW: begin
               lo = $signed(d[18:3]) - int'(d[73:70]);
               hi = $signed(d[18:3]) + int'(d[73:70]);
               if (lo < 0) lo = 0;
               if (hi > n - 1) hi = n - 1;
               for (j = lo; j <= hi; j++) total += counts[j];
               push(0, 0, total, 0, 1);
            end
            default: push(0, 0, 0, 0, 1);
         endcase
      endfunction

      function void check_result(logic [31:0] d, logic lst);
         grid_result_type e;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h last %b", d, lst);
            return;
         end
         e = owed.pop_front();
         if (d[0] !== e.status || d[16:1] !== e.handle_out || d[23:17] !== e.count
             || d[26:24] !== e.peak || lst !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp st %b h %h c %0d pk %0d l %b, got %h l %b",
                        e.status, e.handle_out, e.count, e.peak, e.last, d, lst);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [4:0]  csr_data = 0;
   logic        stall_free = 0;

   grid_scoreboard sb = new();

   bucket_grid_object_store uut (.*);

   always #4 clock = ~clock;

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);

   // receiver stalls at random, except in some stretches
   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (stall_free) rsp_tready <= 1;
         else begin
            g = gap_len();
            if (g == 0) rsp_tready <= 1;
            else begin
               rsp_tready <= 0;
               repeat (g) @(negedge clock);
               rsp_tready <= 1;
            end
         end
      end
   end

   // valid stays up after an accepted item and drops only when a gap follows or on a drain
   task automatic send_item(logic [79:0] d, bit no_gap);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_item(d);
      @(negedge clock);
   endtask

   function automatic logic [79:0] pack_item(opcode_type op, logic [15:0] ci,
         logic [15:0] h, logic [15:0] lo, logic [15:0] hi, logic [2:0] th,
         logic [3:0] rad);
      return {6'd0, rad, th, hi, lo, h, ci, op};
   endfunction

   task automatic drain();
      req_tvalid <= 0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [4:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   // mostly adds to small cells, some selects and scans, a little noise
   function automatic logic [79:0] random_item(int n);
      int pick;
      logic [15:0] ci, lo, hi;
      pick = $urandom_range(0, 99);
      ci = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, n));
      lo = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 17)) - 16'd1;
      hi = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 17));
      if (pick < 45)
         return pack_item(OP_ADD, ci, ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom),
                          lo, hi, 3'($urandom), 4'($urandom));
      if (pick < 65)
         return pack_item(OP_SELECT, ci, 16'($urandom), lo, hi, 3'($urandom), 4'($urandom));
      if (pick < 68) return pack_item(OP_CLEAR, ci, 0, lo, hi, 0, 0);
      if (pick < 76)
         return pack_item(OP_DISCARD, ci, 0, lo, hi, 3'($urandom), 4'($urandom));
      if (pick < 84) return pack_item(OP_PEAK, ci, 0, lo, hi, 0, 0);
      if (pick < 96)
         return pack_item(OP_WINDOW, ci, 16'($urandom), lo, hi, 3'($urandom), 4'($urandom));
      return {6'($urandom), 74'({$urandom, $urandom, $urandom}) | 74'd6};
   endfunction

   initial begin
      int limits[4] = '{4, 1, 0, 7};
      int cellsv[4] = '{16, 1, 31, 0};
      sb.reset_grid();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, rejections, full cells, every opcode
      send_item(pack_item(OP_SELECT, 0, 0, 16'h8000, 16'h7fff, 0, 0), 0);
      for (int k = 0; k < 5; k++)
         send_item(pack_item(OP_ADD, 16'd0, 16'hffff - k, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_ADD, 16'd15, 16'h0001, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_ADD, 16'd16, 16'h1234, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_ADD, 16'hffff, 16'h1234, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_ADD, 16'h8000, 16'h5555, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_ADD, 16'd3, 16'h0000, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_ADD, 16'd3, 16'haaaa, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_SELECT, 0, 0, 16'h8000, 16'h7fff, 0, 0), 0);
      send_item(pack_item(OP_SELECT, 0, 0, 16'd5, 16'd2, 0, 0), 0);
      send_item(pack_item(OP_WINDOW, 16'h7fff, 0, 0, 0, 0, 4'hf), 0);
      send_item(pack_item(OP_WINDOW, 16'h8000, 0, 0, 0, 0, 4'hf), 0);
      send_item(pack_item(OP_WINDOW, 16'd3, 0, 0, 0, 0, 4'd0), 0);
      send_item(pack_item(OP_PEAK, 0, 0, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_DISCARD, 0, 0, 0, 0, 3'd7, 0), 0);
      send_item(pack_item(OP_DISCARD, 0, 0, 0, 0, 3'd1, 0), 0);
      send_item(pack_item(OP_DISCARD, 0, 0, 0, 0, 3'd0, 0), 0);
      send_item(pack_item(OP_RSVD6, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 3'd7, 4'hf), 0);
      send_item(pack_item(OP_RSVD7, 0, 0, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_CLEAR, 0, 0, 0, 0, 0, 0), 0);
      send_item(pack_item(OP_PEAK, 0, 0, 0, 0, 0, 0), 0);
      drain();

      // random phases under several register settings; fill cells then select all
      for (int p = 0; p < 5; p++) begin
         if (p < 4) begin
            write_reg(CSR_CELL_LIMIT, 5'(limits[p]));
            write_reg(CSR_CELLS_IN_USE, 5'(cellsv[p]));
         end else begin
            write_reg(CSR_CELL_LIMIT, 5'd4);
            write_reg(CSR_CELLS_IN_USE, 5'd16);
            for (int j = 0; j < 8; j++)
               for (int k = 0; k < 4; k++)
                  send_item(pack_item(OP_ADD, 16'(j), 16'($urandom_range(1, 65535)),
                                      0, 0, 0, 0), 1);
            send_item(pack_item(OP_SELECT, 0, 0, 16'h8000, 16'h7fff, 0, 0), 0);
         end
         stall_free = (p == 2);
         for (int i = 0; i < 8; i++) begin
            send_item(random_item(16), p == 1);
            if (p == 3 && i == 4) drain();
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.owed.size() == 0)
         $display("bucket_grid_object_store_test OK");
      else
         $display("bucket_grid_object_store_test NOT OK");
      $finish;
   end

   initial begin
      #20000000;
      $display("bucket_grid_object_store_test NOT OK");
      $finish;
   end
endmodule
